FILE: rtl/core/ctt_pkg.sv
// Shared types and constants of the configuration text tokenizer.
package ctt_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LINE_BITS   = 24;
    localparam int COLUMN_BITS = 16;
    localparam int LENGTH_BITS = 16;
    localparam int KIND_BITS   = 4;
    localparam int ERROR_BITS  = 2;

    // Packed result width and its byte-aligned bus width.
    localparam int RESULT_BITS =
        KIND_BITS + ERROR_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS + COLUMN_BITS;
    localparam int OUT_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

    // One input byte causes at most three results.
    localparam int MAX_RESULTS     = 3;
    localparam int QUEUE_DEPTH     = 8;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int KEYWORD_CHARS   = 5;

    // Character codes.
    localparam logic [7:0] CH_SPACE     = " ";
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_HASH      = "#";
    localparam logic [7:0] CH_BACKSLASH = "\\";
    localparam logic [7:0] CH_QUOTE     = "\"";
    localparam logic [7:0] CH_MINUS     = "-";
    localparam logic [7:0] CH_PLUS      = "+";
    localparam logic [7:0] CH_DOT       = ".";
    localparam logic [7:0] CH_LBRACE    = "{";
    localparam logic [7:0] CH_RBRACE    = "}";
    localparam logic [7:0] CH_LBRACKET  = "[";
    localparam logic [7:0] CH_RBRACKET  = "]";
    localparam logic [7:0] CH_COLON     = ":";
    localparam logic [7:0] CH_COMMA     = ",";
    localparam logic [7:0] CH_UNDERLINE = "_";

    // Keyword letters after the first one.
    localparam logic [31:0] KW_FALSE_TAIL = "alse";
    localparam logic [23:0] KW_NULL_TAIL  = "ull";
    localparam logic [23:0] KW_TRUE_TAIL  = "rue";

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_IDENT,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC,
        MODE_EXP,
        MODE_EXPSIGN,
        MODE_EXPDIG,
        MODE_STR,
        MODE_STRESC
    } scan_mode_t;

    typedef enum logic [KIND_BITS-1:0] {
        TOK_EOF,
        TOK_LBRACE,
        TOK_RBRACE,
        TOK_LBRACKET,
        TOK_RBRACKET,
        TOK_COLON,
        TOK_COMMA,
        TOK_STRING,
        TOK_INTEGER,
        TOK_FLOAT,
        TOK_IDENT,
        TOK_TRUE,
        TOK_FALSE,
        TOK_NULL,
        TOK_ERROR
    } token_kind_t;

    typedef enum logic [ERROR_BITS-1:0] {
        ERR_NONE,
        ERR_UNTERMINATED,
        ERR_EXPONENT,
        ERR_UNEXPECTED
    } error_code_t;

    typedef struct packed {
        token_kind_t             kind;
        error_code_t             err;
        logic [OFFSET_BITS-1:0]  offset;
        logic [LENGTH_BITS-1:0]  length;
        logic [LINE_BITS-1:0]    line;
        logic [COLUMN_BITS-1:0]  column;
        logic                    last;
    } result_t;

endpackage

FILE: rtl/core/config_text_tokenizer.sv
// Top level of the configuration text tokenizer: scanner and result queue.
//
// Usage: source bytes arrive on the slave stream, one per transfer, with
// s_tuser low; a transfer with s_tuser high marks the end of the source.
// Tokens leave on the master stream, one per transfer, each with kind,
// error code, start offset, length, line and start column in m_tdata.
// m_tlast marks the last token caused by one input transfer.
//
// Each accepted input is scanned in the cycle of its transfer and its
// zero to three tokens are written into an eight-entry result queue; no
// token leaves on the master side in the cycle of its input transfer.
// The block takes one input per cycle as long as the queue has room for
// three more tokens, so with m_tready high a text yielding at most one
// token per byte streams at one byte per cycle; bursts of two or three
// tokens drain at one token per cycle through the single queue read port.
//
// Reset empties the queue and puts the scanner between tokens at line 1,
// column 1, offset 0. End of source flushes any pending token, emits EOF
// and returns the scanner to that same state. When the receiver stalls,
// tokens collect in the queue and s_tready falls once fewer than three
// entries are free.
module config_text_tokenizer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // byte_value
    input  logic                               s_tuser,   // kind (1 = end of source)
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // token_kind, error_code, start_offset, token_length, line_number,
    // first_column, zero padding
    output logic [ctt_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    output logic                               m_tlast     // last_of_run
);

    localparam int OB = ctt_pkg::OFFSET_BITS;
    localparam int LB = ctt_pkg::LINE_BITS;
    localparam int CB = ctt_pkg::COLUMN_BITS;
    localparam int NB = ctt_pkg::LENGTH_BITS;
    localparam int PB = ctt_pkg::QUEUE_PTR_BITS;
    localparam int QB = ctt_pkg::QUEUE_CNT_BITS;

    // Scanner state.
    ctt_pkg::scan_mode_t mode_reg, mode_next;
    logic [OB-1:0] offset_reg, offset_next;
    logic [LB-1:0] line_reg, line_next;
    logic [CB-1:0] column_reg, column_next;
    logic [OB-1:0] tok_offset_reg, tok_offset_next;
    logic [CB-1:0] tok_column_reg, tok_column_next;
    logic [NB-1:0] tok_len_reg, tok_len_next;
    logic [OB-1:0] dot_offset_reg, dot_offset_next;
    logic [CB-1:0] dot_column_reg, dot_column_next;
    logic [7:0]    keyword_reg [ctt_pkg::KEYWORD_CHARS];
    logic [7:0]    keyword_next [ctt_pkg::KEYWORD_CHARS];

    // Result queue.
    ctt_pkg::result_t queue_mem [ctt_pkg::QUEUE_DEPTH];
    logic [PB-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QB-1:0] count_reg, count_next;

    ctt_pkg::result_t res [ctt_pkg::MAX_RESULTS];
    logic [1:0]       res_count;
    logic             accept;
    logic             pop;
    logic             do_fresh;
    logic [7:0]       ch;
    ctt_pkg::result_t head;

    function automatic logic [OB-1:0] sat_offset(input logic [OB-1:0] v);
        return (v == '1) ? v : v + OB'(1);
    endfunction

    function automatic logic [LB-1:0] sat_line(input logic [LB-1:0] v);
        return (v == '1) ? v : v + LB'(1);
    endfunction

    function automatic logic [CB-1:0] sat_column(input logic [CB-1:0] v);
        return (v == '1) ? v : v + CB'(1);
    endfunction

    function automatic logic [NB-1:0] sat_length(input logic [NB-1:0] v);
        return (v == '1) ? v : v + NB'(1);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
            || (c == ctt_pkg::CH_UNDERLINE);
    endfunction

    function automatic ctt_pkg::result_t make_result(
        input ctt_pkg::token_kind_t kind,
        input ctt_pkg::error_code_t err,
        input logic [OB-1:0]        offset,
        input logic [NB-1:0]        length,
        input logic [LB-1:0]        line,
        input logic [CB-1:0]        column
    );
        ctt_pkg::result_t r;
        r.kind   = kind;
        r.err    = err;
        r.offset = offset;
        r.length = length;
        r.line   = line;
        r.column = column;
        r.last   = 1'b0;
        return r;
    endfunction

    // Keyword check on the stored first five letters of an identifier.
    function automatic ctt_pkg::token_kind_t ident_kind(
        input logic [NB-1:0] len,
        input logic [7:0]    kw [ctt_pkg::KEYWORD_CHARS]
    );
        ctt_pkg::token_kind_t k;
        k = ctt_pkg::TOK_IDENT;
        if ((len == NB'(5)) && (kw[0] == "f")
            && ({kw[1], kw[2], kw[3], kw[4]} == ctt_pkg::KW_FALSE_TAIL))
        begin
            k = ctt_pkg::TOK_FALSE;
        end
        else if ((len == NB'(4)) && (kw[0] == "n")
            && ({kw[1], kw[2], kw[3]} == ctt_pkg::KW_NULL_TAIL))
        begin
            k = ctt_pkg::TOK_NULL;
        end
        else if ((len == NB'(4)) && (kw[0] == "t")
            && ({kw[1], kw[2], kw[3]} == ctt_pkg::KW_TRUE_TAIL))
        begin
            k = ctt_pkg::TOK_TRUE;
        end
        return k;
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign ch       = s_tdata;
    assign s_tready = (count_reg <= QB'(ctt_pkg::QUEUE_DEPTH - ctt_pkg::MAX_RESULTS));
    assign m_tvalid = (count_reg != '0);

    assign head    = queue_mem[rd_ptr_reg];
    assign m_tdata = ctt_pkg::OUT_TDATA_BITS'({head.column, head.line, head.length,
                                               head.offset, head.err, head.kind});
    assign m_tlast = head.last;

    // Scanner: one input item per pass, results collected in order.
    always_comb
    begin
        mode_next       = mode_reg;
        offset_next     = offset_reg;
        line_next       = line_reg;
        column_next     = column_reg;
        tok_offset_next = tok_offset_reg;
        tok_column_next = tok_column_reg;
        tok_len_next    = tok_len_reg;
        dot_offset_next = dot_offset_reg;
        dot_column_next = dot_column_reg;
        keyword_next    = keyword_reg;
        do_fresh        = 1'b0;
        res_count       = 2'd0;
        for (int i = 0; i < ctt_pkg::MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end

        if (s_tuser)
        begin
            // End of source: flush the pending token, then EOF.
            unique case (mode_reg)
                ctt_pkg::MODE_IDENT:
                begin
                    res[res_count] = make_result(ident_kind(tok_len_reg, keyword_reg),
                        ctt_pkg::ERR_NONE, tok_offset_reg, tok_len_reg, line_reg,
                        tok_column_reg);
                    res_count = res_count + 2'd1;
                end
                ctt_pkg::MODE_INT:
                begin
                    res[res_count] = make_result(ctt_pkg::TOK_INTEGER, ctt_pkg::ERR_NONE,
                        tok_offset_reg, tok_len_reg, line_reg, tok_column_reg);
                    res_count = res_count + 2'd1;
                end
                ctt_pkg::MODE_DOT:
                begin
                    res[res_count] = make_result(ctt_pkg::TOK_INTEGER, ctt_pkg::ERR_NONE,
                        tok_offset_reg, tok_len_reg, line_reg, tok_column_reg);
                    res_count = res_count + 2'd1;
                    res[res_count] = make_result(ctt_pkg::TOK_ERROR,
                        ctt_pkg::ERR_UNEXPECTED, dot_offset_reg, '0, line_reg,
                        dot_column_reg);
                    res_count = res_count + 2'd1;
                end
                ctt_pkg::MODE_FRAC, ctt_pkg::MODE_EXPDIG:
                begin
                    res[res_count] = make_result(ctt_pkg::TOK_FLOAT, ctt_pkg::ERR_NONE,
                        tok_offset_reg, tok_len_reg, line_reg, tok_column_reg);
                    res_count = res_count + 2'd1;
                end
                ctt_pkg::MODE_EXP, ctt_pkg::MODE_EXPSIGN:
                begin
                    res[res_count] = make_result(ctt_pkg::TOK_ERROR, ctt_pkg::ERR_EXPONENT,
                        tok_offset_reg, '0, line_reg, tok_column_reg);
                    res_count = res_count + 2'd1;
                end
                ctt_pkg::MODE_STR, ctt_pkg::MODE_STRESC:
                begin
                    res[res_count] = make_result(ctt_pkg::TOK_ERROR,
                        ctt_pkg::ERR_UNTERMINATED, tok_offset_reg, '0, line_reg,
                        tok_column_reg);
                    res_count = res_count + 2'd1;
                end
                default:
                begin
                end
            endcase
            res[res_count] = make_result(ctt_pkg::TOK_EOF, ctt_pkg::ERR_NONE,
                offset_reg, '0, line_reg, column_reg);
            res_count = res_count + 2'd1;

            mode_next       = ctt_pkg::MODE_IDLE;
            offset_next     = '0;
            line_next       = LB'(1);
            column_next     = CB'(1);
            tok_offset_next = '0;
            tok_column_next = CB'(1);
            tok_len_next    = '0;
            dot_offset_next = '0;
            dot_column_next = CB'(1);
        end
        else
        begin
            unique case (mode_reg)
                ctt_pkg::MODE_COMMENT:
                begin
                    if (ch == ctt_pkg::CH_LF)
                    begin
                        do_fresh = 1'b1;
                    end
                    else
                    begin
                        offset_next = sat_offset(offset_next);
                        column_next = sat_column(column_next);
                    end
                end
                ctt_pkg::MODE_IDENT:
                begin
                    if (is_letter(ch) || is_numeral(ch) || (ch == ctt_pkg::CH_MINUS))
                    begin
                        if (tok_len_reg < NB'(ctt_pkg::KEYWORD_CHARS))
                        begin
                            keyword_next[tok_len_reg[2:0]] = ch;
                        end
                        tok_len_next = sat_length(tok_len_next);
                        offset_next  = sat_offset(offset_next);
                        column_next  = sat_column(column_next);
                    end
                    else
                    begin
                        res[res_count] = make_result(ident_kind(tok_len_reg, keyword_reg),
                            ctt_pkg::ERR_NONE, tok_offset_reg, tok_len_reg, line_reg,
                            tok_column_reg);
                        res_count = res_count + 2'd1;
                        do_fresh  = 1'b1;
                    end
                end
                ctt_pkg::MODE_INT:
                begin
                    if (is_numeral(ch))
                    begin
                        tok_len_next = sat_length(tok_len_next);
                        offset_next  = sat_offset(offset_next);
                        column_next  = sat_column(column_next);
                    end
                    else if (ch == ctt_pkg::CH_DOT)
                    begin
                        dot_offset_next = offset_reg;
                        dot_column_next = column_reg;
                        offset_next     = sat_offset(offset_next);
                        column_next     = sat_column(column_next);
                        mode_next       = ctt_pkg::MODE_DOT;
                    end
                    else if ((ch == "e") || (ch == "E"))
                    begin
                        tok_len_next = sat_length(tok_len_next);
                        offset_next  = sat_offset(offset_next);
                        column_next  = sat_column(column_next);
                        mode_next    = ctt_pkg::MODE_EXP;
                    end
                    else
                    begin
                        res[res_count] = make_result(ctt_pkg::TOK_INTEGER,
                            ctt_pkg::ERR_NONE, tok_offset_reg, tok_len_reg, line_reg,
                            tok_column_reg);
                        res_count = res_count + 2'd1;
                        do_fresh  = 1'b1;
                    end
                end
                ctt_pkg::MODE_DOT:
                begin
                    if (is_numeral(ch))
                    begin
                        // The dot and the digit both join the token.
                        tok_len_next = sat_length(sat_length(tok_len_next));
                        offset_next  = sat_offset(offset_next);
                        column_next  = sat_column(column_next);
                        mode_next    = ctt_pkg::MODE_FRAC;
                    end
                    else
                    begin
                        res[res_count] = make_result(ctt_pkg::TOK_INTEGER,
                            ctt_pkg::ERR_NONE, tok_offset_reg, tok_len_reg, line_reg,
                            tok_column_reg);
                        res_count = res_count + 2'd1;
                        res[res_count] = make_result(ctt_pkg::TOK_ERROR,
                            ctt_pkg::ERR_UNEXPECTED, dot_offset_reg, '0, line_reg,
                            dot_column_reg);
                        res_count = res_count + 2'd1;
                        do_fresh  = 1'b1;
                    end
                end
                ctt_pkg::MODE_FRAC:
                begin
                    if (is_numeral(ch))
                    begin
                        tok_len_next = sat_length(tok_len_next);
                        offset_next  = sat_offset(offset_next);
                        column_next  = sat_column(column_next);
                    end
                    else if ((ch == "e") || (ch == "E"))
                    begin
                        tok_len_next = sat_length(tok_len_next);
                        offset_next  = sat_offset(offset_next);
                        column_next  = sat_column(column_next);
                        mode_next    = ctt_pkg::MODE_EXP;
                    end
                    else
                    begin
                        res[res_count] = make_result(ctt_pkg::TOK_FLOAT,
                            ctt_pkg::ERR_NONE, tok_offset_reg, tok_len_reg, line_reg,
                            tok_column_reg);
                        res_count = res_count + 2'd1;
                        do_fresh  = 1'b1;
                    end
                end
                ctt_pkg::MODE_EXP:
                begin
                    if ((ch == ctt_pkg::CH_PLUS) || (ch == ctt_pkg::CH_MINUS))
                    begin
                        tok_len_next = sat_length(tok_len_next);
                        offset_next  = sat_offset(offset_next);
                        column_next  = sat_column(column_next);
                        mode_next    = ctt_pkg::MODE_EXPSIGN;
                    end
                    else if (is_numeral(ch))
                    begin
                        tok_len_next = sat_length(tok_len_next);
                        offset_next  = sat_offset(offset_next);
                        column_next  = sat_column(column_next);
                        mode_next    = ctt_pkg::MODE_EXPDIG;
                    end
                    else
                    begin
                        res[res_count] = make_result(ctt_pkg::TOK_ERROR,
                            ctt_pkg::ERR_EXPONENT, tok_offset_reg, '0, line_reg,
                            tok_column_reg);
                        res_count = res_count + 2'd1;
                        do_fresh  = 1'b1;
                    end
                end
                ctt_pkg::MODE_EXPSIGN:
                begin
                    if (is_numeral(ch))
                    begin
                        tok_len_next = sat_length(tok_len_next);
                        offset_next  = sat_offset(offset_next);
                        column_next  = sat_column(column_next);
                        mode_next    = ctt_pkg::MODE_EXPDIG;
                    end
                    else
                    begin
                        res[res_count] = make_result(ctt_pkg::TOK_ERROR,
                            ctt_pkg::ERR_EXPONENT, tok_offset_reg, '0, line_reg,
                            tok_column_reg);
                        res_count = res_count + 2'd1;
                        do_fresh  = 1'b1;
                    end
                end
                ctt_pkg::MODE_EXPDIG:
                begin
                    if (is_numeral(ch))
                    begin
                        tok_len_next = sat_length(tok_len_next);
                        offset_next  = sat_offset(offset_next);
                        column_next  = sat_column(column_next);
                    end
                    else
                    begin
                        res[res_count] = make_result(ctt_pkg::TOK_FLOAT,
                            ctt_pkg::ERR_NONE, tok_offset_reg, tok_len_reg, line_reg,
                            tok_column_reg);
                        res_count = res_count + 2'd1;
                        do_fresh  = 1'b1;
                    end
                end
                ctt_pkg::MODE_STR:
                begin
                    tok_len_next = sat_length(tok_len_next);
                    offset_next  = sat_offset(offset_next);
                    column_next  = sat_column(column_next);
                    if (ch == ctt_pkg::CH_QUOTE)
                    begin
                        res[res_count] = make_result(ctt_pkg::TOK_STRING,
                            ctt_pkg::ERR_NONE, tok_offset_reg, tok_len_next, line_reg,
                            tok_column_reg);
                        res_count = res_count + 2'd1;
                        mode_next = ctt_pkg::MODE_IDLE;
                    end
                    else if (ch == ctt_pkg::CH_BACKSLASH)
                    begin
                        mode_next = ctt_pkg::MODE_STRESC;
                    end
                    else if (ch == ctt_pkg::CH_LF)
                    begin
                        // A raw newline inside a string starts a new line.
                        line_next   = sat_line(line_reg);
                        column_next = CB'(1);
                    end
                end
                ctt_pkg::MODE_STRESC:
                begin
                    tok_len_next = sat_length(tok_len_next);
                    offset_next  = sat_offset(offset_next);
                    column_next  = sat_column(column_next);
                    mode_next    = ctt_pkg::MODE_STR;
                end
                default:
                begin
                    do_fresh = 1'b1;
                end
            endcase

            // Scan the byte as the possible start of a new token.
            if (do_fresh)
            begin
                mode_next = ctt_pkg::MODE_IDLE;
                priority if ((ch == ctt_pkg::CH_SPACE) || (ch == ctt_pkg::CH_CR)
                             || (ch == ctt_pkg::CH_TAB))
                begin
                    offset_next = sat_offset(offset_next);
                    column_next = sat_column(column_next);
                end
                else if (ch == ctt_pkg::CH_LF)
                begin
                    offset_next = sat_offset(offset_next);
                    line_next   = sat_line(line_next);
                    column_next = CB'(1);
                end
                else if (ch == ctt_pkg::CH_HASH)
                begin
                    offset_next = sat_offset(offset_next);
                    column_next = sat_column(column_next);
                    mode_next   = ctt_pkg::MODE_COMMENT;
                end
                else
                begin
                    tok_offset_next = offset_next;
                    tok_column_next = column_next;
                    tok_len_next    = NB'(1);
                    offset_next     = sat_offset(offset_next);
                    column_next     = sat_column(column_next);
                    if (is_letter(ch))
                    begin
                        keyword_next[0] = ch;
                        mode_next       = ctt_pkg::MODE_IDENT;
                    end
                    else if (is_numeral(ch) || (ch == ctt_pkg::CH_MINUS))
                    begin
                        mode_next = ctt_pkg::MODE_INT;
                    end
                    else if (ch == ctt_pkg::CH_QUOTE)
                    begin
                        mode_next = ctt_pkg::MODE_STR;
                    end
                    else
                    begin
                        unique case (ch)
                            ctt_pkg::CH_LBRACE:
                                res[res_count] = make_result(ctt_pkg::TOK_LBRACE,
                                    ctt_pkg::ERR_NONE, tok_offset_next, tok_len_next,
                                    line_next, tok_column_next);
                            ctt_pkg::CH_RBRACE:
                                res[res_count] = make_result(ctt_pkg::TOK_RBRACE,
                                    ctt_pkg::ERR_NONE, tok_offset_next, tok_len_next,
                                    line_next, tok_column_next);
                            ctt_pkg::CH_LBRACKET:
                                res[res_count] = make_result(ctt_pkg::TOK_LBRACKET,
                                    ctt_pkg::ERR_NONE, tok_offset_next, tok_len_next,
                                    line_next, tok_column_next);
                            ctt_pkg::CH_RBRACKET:
                                res[res_count] = make_result(ctt_pkg::TOK_RBRACKET,
                                    ctt_pkg::ERR_NONE, tok_offset_next, tok_len_next,
                                    line_next, tok_column_next);
                            ctt_pkg::CH_COLON:
                                res[res_count] = make_result(ctt_pkg::TOK_COLON,
                                    ctt_pkg::ERR_NONE, tok_offset_next, tok_len_next,
                                    line_next, tok_column_next);
                            ctt_pkg::CH_COMMA:
                                res[res_count] = make_result(ctt_pkg::TOK_COMMA,
                                    ctt_pkg::ERR_NONE, tok_offset_next, tok_len_next,
                                    line_next, tok_column_next);
                            default:
                                res[res_count] = make_result(ctt_pkg::TOK_ERROR,
                                    ctt_pkg::ERR_UNEXPECTED, tok_offset_next, '0,
                                    line_next, tok_column_next);
                        endcase
                        res_count = res_count + 2'd1;
                    end
                end
            end
        end

        // The final result of this item carries the run marker.
        for (int i = 0; i < ctt_pkg::MAX_RESULTS; i++)
        begin
            res[i].last = (2'(i) == (res_count - 2'd1));
        end
    end

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + PB'(res_count);
            count_next  = count_next + QB'(res_count);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PB'(1);
            count_next  = count_next - QB'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ctt_pkg::MODE_IDLE;
            offset_reg     <= '0;
            line_reg       <= LB'(1);
            column_reg     <= CB'(1);
            tok_offset_reg <= '0;
            tok_column_reg <= CB'(1);
            tok_len_reg    <= '0;
            dot_offset_reg <= '0;
            dot_column_reg <= CB'(1);
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg       <= mode_next;
                offset_reg     <= offset_next;
                line_reg       <= line_next;
                column_reg     <= column_next;
                tok_offset_reg <= tok_offset_next;
                tok_column_reg <= tok_column_next;
                tok_len_reg    <= tok_len_next;
                dot_offset_reg <= dot_offset_next;
                dot_column_reg <= dot_column_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Keyword letters and queue entries hold payload only.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            keyword_reg <= keyword_next;
            for (int i = 0; i < ctt_pkg::MAX_RESULTS; i++)
            begin
                if (2'(i) < res_count)
                begin
                    queue_mem[wr_ptr_reg + PB'(i)] <= res[i];
                end
            end
        end
    end

endmodule

FILE: rtl/core/ctt_checker.sv
// Port-level checks of the configuration text tokenizer and their binding.
module ctt_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [ctt_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    input logic                               m_tlast
);

    localparam int KB = ctt_pkg::KIND_BITS;
    localparam int EB = ctt_pkg::ERROR_BITS;
    localparam int LEN_LO = KB + EB + ctt_pkg::OFFSET_BITS;

    logic [KB-1:0] out_kind;
    logic [EB-1:0] out_err;
    logic [ctt_pkg::LENGTH_BITS-1:0] out_len;

    assign out_kind = m_tdata[KB-1:0];
    assign out_err  = m_tdata[KB+EB-1:KB];
    assign out_len  = m_tdata[LEN_LO+ctt_pkg::LENGTH_BITS-1:LEN_LO];

    // The queue stays empty through reset.
    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    // A stalled token keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled token changed");

    // End of source always yields at least the EOF token.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> m_tvalid)
        else $error("no token after end of source");

    // EOF closes the run of its input.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_kind == KB'(ctt_pkg::TOK_EOF)) |-> m_tlast)
        else $error("EOF token without run marker");

    // Error tokens carry a code and no length; other tokens carry no code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_kind == KB'(ctt_pkg::TOK_ERROR))
                      ? ((out_err != EB'(ctt_pkg::ERR_NONE)) && (out_len == '0))
                      : (out_err == EB'(ctt_pkg::ERR_NONE))))
        else $error("error code and token kind disagree");

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: tb/testbench.sv
// Self-checking testbench of the text tokenizer: lexer model, stream driver and token checker.
`timescale 1ns / 1ps

module testbench;

    import ctt_pkg::*;

    // Bit positions of the token fields in m_tdata, from the lowest bit up.
    localparam int KIND_LSB   = 0;
    localparam int ERROR_LSB  = KIND_LSB + KIND_BITS;
    localparam int OFFSET_LSB = ERROR_LSB + ERROR_BITS;
    localparam int LENGTH_LSB = OFFSET_LSB + OFFSET_BITS;
    localparam int LINE_LSB   = LENGTH_LSB + LENGTH_BITS;
    localparam int COLUMN_LSB = LINE_LSB + LINE_BITS;

    // Least number of input items before the final end-of-source mark, the directed ones included.
    localparam int SOURCE_ITEMS = 350;

    // Window of cycles in which neither side of the block inserts gaps.
    localparam int QUIET_FROM = 150;
    localparam int QUIET_TO   = 450;

    // One source item: a byte, or the end-of-source mark.
    typedef struct packed {
        logic       eos;
        logic [7:0] value;
    } source_item_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata = '0;
    logic                      s_tuser = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tlast;

    config_text_tokenizer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Free-running clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Source items still to be driven, and tokens predicted but not yet seen.
    source_item_t source_bytes[$];
    result_t      token_queue[$];
    source_item_t next_item;

    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    int unsigned eos_sent = 0;
    int unsigned tokens_checked = 0;
    logic [15:0] kinds_seen = '0;
    logic [3:0]  errors_seen = '0;

    // ------------------------------------------------------------------
    // Lexer model. It mirrors the scanner state and, for every input
    // transfer, appends the tokens that transfer causes to token_queue.
    // ------------------------------------------------------------------
    scan_mode_t             lex_mode;
    logic [OFFSET_BITS-1:0] src_offset;
    logic [LINE_BITS-1:0]   src_line;
    logic [COLUMN_BITS-1:0] src_col;
    logic [OFFSET_BITS-1:0] tok_offset;
    logic [COLUMN_BITS-1:0] tok_col;
    logic [LENGTH_BITS-1:0] tok_len;
    logic [OFFSET_BITS-1:0] dot_offset;
    logic [COLUMN_BITS-1:0] dot_col;
    logic [7:0]             kw_chars [KEYWORD_CHARS];
    result_t                burst[$];

    task automatic lexer_reset();
        lex_mode   = MODE_IDLE;
        src_offset = '0;
        src_line   = LINE_BITS'(1);
        src_col    = COLUMN_BITS'(1);
        tok_offset = '0;
        tok_col    = COLUMN_BITS'(1);
        tok_len    = '0;
        dot_offset = '0;
        dot_col    = COLUMN_BITS'(1);
        foreach (kw_chars[i]) kw_chars[i] = '0;
    endtask

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERLINE;
    endfunction

    // The line number is taken when the token is emitted, not when it starts.
    task automatic add_token(input token_kind_t kind, input error_code_t code,
                             input logic [OFFSET_BITS-1:0] off,
                             input logic [LENGTH_BITS-1:0] len,
                             input logic [COLUMN_BITS-1:0] col);
        result_t r;
        r.kind   = kind;
        r.err    = code;
        r.offset = off;
        r.length = len;
        r.line   = src_line;
        r.column = col;
        r.last   = 1'b0;
        burst.push_back(r);
    endtask

    task automatic add_pending(input token_kind_t kind);
        add_token(kind, ERR_NONE, tok_offset, tok_len, tok_col);
    endtask

    task automatic add_error(input error_code_t code);
        add_token(TOK_ERROR, code, tok_offset, '0, tok_col);
    endtask

    task automatic add_dot_error();
        add_token(TOK_ERROR, ERR_UNEXPECTED, dot_offset, '0, dot_col);
    endtask

    // Every counter sticks at its all-ones value.
    task automatic advance_column();
        if (src_offset != '1) src_offset++;
        if (src_col != '1) src_col++;
    endtask

    task automatic take_byte();
        advance_column();
        if (tok_len != '1) tok_len++;
    endtask

    task automatic new_line();
        if (src_line != '1) src_line++;
        src_col = COLUMN_BITS'(1);
    endtask

    // A token of four or five letters may be a keyword; only then are the
    // stored letters compared, so none of them is stale.
    function automatic token_kind_t word_kind();
        if (tok_len == 5 &&
            {kw_chars[0], kw_chars[1], kw_chars[2], kw_chars[3], kw_chars[4]} == "false")
            return TOK_FALSE;
        if (tok_len == 4 && {kw_chars[0], kw_chars[1], kw_chars[2], kw_chars[3]} == "null")
            return TOK_NULL;
        if (tok_len == 4 && {kw_chars[0], kw_chars[1], kw_chars[2], kw_chars[3]} == "true")
            return TOK_TRUE;
        return TOK_IDENT;
    endfunction

    // Scans a byte from the state between tokens.
    task automatic scan_fresh(input logic [7:0] c);
        lex_mode = MODE_IDLE;
        if (c == CH_SPACE || c == CH_CR || c == CH_TAB)
        begin
            advance_column();
        end
        else if (c == CH_LF)
        begin
            if (src_offset != '1) src_offset++;
            new_line();
        end
        else if (c == CH_HASH)
        begin
            advance_column();
            lex_mode = MODE_COMMENT;
        end
        else
        begin
            tok_offset = src_offset;
            tok_col    = src_col;
            tok_len    = '0;
            take_byte();
            if (is_letter(c))
            begin
                kw_chars[0] = c;
                lex_mode = MODE_IDENT;
            end
            else if (is_numeral(c) || c == CH_MINUS)
            begin
                lex_mode = MODE_INT;
            end
            else
            begin
                case (c)
                    CH_LBRACE:   add_pending(TOK_LBRACE);
                    CH_RBRACE:   add_pending(TOK_RBRACE);
                    CH_LBRACKET: add_pending(TOK_LBRACKET);
                    CH_RBRACKET: add_pending(TOK_RBRACKET);
                    CH_COLON:    add_pending(TOK_COLON);
                    CH_COMMA:    add_pending(TOK_COMMA);
                    CH_QUOTE:    lex_mode = MODE_STR;
                    default:     add_error(ERR_UNEXPECTED);
                endcase
            end
        end
    endtask

    // Predicts the tokens of one accepted input transfer.
    task automatic lex_item(input logic eos, input logic [7:0] c);
        burst.delete();
        if (eos)
        begin
            // End of source flushes the pending token, then reports EOF.
            case (lex_mode)
                MODE_IDENT:                add_pending(word_kind());
                MODE_INT:                  add_pending(TOK_INTEGER);
                MODE_DOT:
                begin
                    add_pending(TOK_INTEGER);
                    add_dot_error();
                end
                MODE_FRAC, MODE_EXPDIG:    add_pending(TOK_FLOAT);
                MODE_EXP, MODE_EXPSIGN:    add_error(ERR_EXPONENT);
                MODE_STR, MODE_STRESC:     add_error(ERR_UNTERMINATED);
                default: ;
            endcase
            add_token(TOK_EOF, ERR_NONE, src_offset, '0, src_col);
        end
        else
        begin
            case (lex_mode)
                MODE_COMMENT:
                    if (c == CH_LF) scan_fresh(c);
                    else advance_column();
                MODE_IDENT:
                    if (is_letter(c) || is_numeral(c) || c == CH_MINUS)
                    begin
                        if (tok_len < KEYWORD_CHARS) kw_chars[tok_len[2:0]] = c;
                        take_byte();
                    end
                    else
                    begin
                        add_pending(word_kind());
                        scan_fresh(c);
                    end
                MODE_INT:
                    if (is_numeral(c))
                        take_byte();
                    else if (c == CH_DOT)
                    begin
                        // The dot joins the number only if a digit follows it.
                        dot_offset = src_offset;
                        dot_col    = src_col;
                        advance_column();
                        lex_mode = MODE_DOT;
                    end
                    else if (c == "e" || c == "E")
                    begin
                        take_byte();
                        lex_mode = MODE_EXP;
                    end
                    else
                    begin
                        add_pending(TOK_INTEGER);
                        scan_fresh(c);
                    end
                MODE_DOT:
                    if (is_numeral(c))
                    begin
                        // The dot is counted into the length now.
                        if (tok_len != '1) tok_len++;
                        take_byte();
                        lex_mode = MODE_FRAC;
                    end
                    else
                    begin
                        add_pending(TOK_INTEGER);
                        add_dot_error();
                        scan_fresh(c);
                    end
                MODE_FRAC:
                    if (is_numeral(c))
                        take_byte();
                    else if (c == "e" || c == "E")
                    begin
                        take_byte();
                        lex_mode = MODE_EXP;
                    end
                    else
                    begin
                        add_pending(TOK_FLOAT);
                        scan_fresh(c);
                    end
                MODE_EXP:
                    if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        take_byte();
                        lex_mode = MODE_EXPSIGN;
                    end
                    else if (is_numeral(c))
                    begin
                        take_byte();
                        lex_mode = MODE_EXPDIG;
                    end
                    else
                    begin
                        add_error(ERR_EXPONENT);
                        scan_fresh(c);
                    end
                MODE_EXPSIGN:
                    if (is_numeral(c))
                    begin
                        take_byte();
                        lex_mode = MODE_EXPDIG;
                    end
                    else
                    begin
                        add_error(ERR_EXPONENT);
                        scan_fresh(c);
                    end
                MODE_EXPDIG:
                    if (is_numeral(c))
                        take_byte();
                    else
                    begin
                        add_pending(TOK_FLOAT);
                        scan_fresh(c);
                    end
                MODE_STR:
                    if (c == CH_QUOTE)
                    begin
                        take_byte();
                        add_pending(TOK_STRING);
                        lex_mode = MODE_IDLE;
                    end
                    else if (c == CH_BACKSLASH)
                    begin
                        take_byte();
                        lex_mode = MODE_STRESC;
                    end
                    else if (c == CH_LF)
                    begin
                        // A raw line feed inside a string still starts a new line.
                        take_byte();
                        new_line();
                    end
                    else
                        take_byte();
                MODE_STRESC:
                begin
                    // The escaped byte is taken as it is, even a line feed.
                    take_byte();
                    lex_mode = MODE_STR;
                end
                default:
                    scan_fresh(c);
            endcase
        end
        if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i]) token_queue.push_back(burst[i]);
        if (eos) lexer_reset();
    endtask

    // ------------------------------------------------------------------
    // Token checker.
    // ------------------------------------------------------------------
    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_token();
        result_t want;
        tokens_checked++;
        if (token_queue.size() == 0)
        begin
            $error("token transfer with nothing expected: kind %0d, offset %0d",
                   m_tdata[KIND_LSB +: KIND_BITS], m_tdata[OFFSET_LSB +: OFFSET_BITS]);
            mismatch_count++;
            return;
        end
        want = token_queue.pop_front();
        kinds_seen[want.kind] = 1'b1;
        errors_seen[want.err] = 1'b1;
        compare_field("token_kind",   want.kind,   m_tdata[KIND_LSB   +: KIND_BITS]);
        compare_field("error_code",   want.err,    m_tdata[ERROR_LSB  +: ERROR_BITS]);
        compare_field("start_offset", want.offset, m_tdata[OFFSET_LSB +: OFFSET_BITS]);
        compare_field("token_length", want.length, m_tdata[LENGTH_LSB +: LENGTH_BITS]);
        compare_field("line_number",  want.line,   m_tdata[LINE_LSB   +: LINE_BITS]);
        compare_field("first_column", want.column, m_tdata[COLUMN_LSB +: COLUMN_BITS]);
        compare_field("last_of_run",  want.last,   m_tlast);
    endtask

    // Both stream sides go quiet about a third of the time, except in one
    // window where traffic flows back to back.
    function automatic bit take_gap();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
        return $urandom_range(0, 99) < 32;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Source driver. A new transfer is offered once the previous one has been
    // taken, so tvalid and the data stay put while the block holds tready low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (source_bytes.size() != 0 && !take_gap())
            begin
                next_item = source_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_item.value;
                s_tuser  <= next_item.eos;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Token receiver with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !take_gap();
    end

    // Monitor. Tokens are checked before the model runs on the same edge;
    // a token never leaves in the cycle of the transfer that causes it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready) check_token();
            if (s_tvalid && s_tready)
            begin
                items_sent++;
                if (s_tuser) eos_sent++;
                lex_item(s_tuser, s_tdata);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] c);
        source_item_t it;
        it.eos   = 1'b0;
        it.value = c;
        source_bytes.push_back(it);
    endtask

    task automatic push_eos();
        source_item_t it;
        it.eos   = 1'b1;
        it.value = 8'($urandom_range(0, 255));
        source_bytes.push_back(it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    function automatic logic [7:0] random_letter();
        int unsigned r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'("a") + 8'(r);
        if (r < 52) return 8'("A") + 8'(r - 26);
        return CH_UNDERLINE;
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'("0") + 8'($urandom_range(0, 9));
    endfunction

    // Appends one lexeme with random content. Most are well formed; some are
    // cut short or broken so that every error path is reached.
    task automatic add_random_lexeme();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  c;
        string       word;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            case ($urandom_range(0, 5))
                0: push_byte(CH_LBRACE);
                1: push_byte(CH_RBRACE);
                2: push_byte(CH_LBRACKET);
                3: push_byte(CH_RBRACKET);
                4: push_byte(CH_COLON);
                default: push_byte(CH_COMMA);
            endcase
        end
        else if (pick < 28)
        begin
            // Quoted string with escapes, raw line feeds and arbitrary bytes.
            push_byte(CH_QUOTE);
            n = $urandom_range(0, 8);
            repeat (n)
            begin
                case ($urandom_range(0, 5))
                    0:
                    begin
                        push_byte(CH_BACKSLASH);
                        push_byte(8'($urandom_range(0, 255)));
                    end
                    1: push_byte(CH_LF);
                    2:
                    begin
                        c = 8'($urandom_range(0, 255));
                        push_byte((c == CH_QUOTE || c == CH_BACKSLASH) ? 8'("z") : c);
                    end
                    default: push_byte(random_letter());
                endcase
            end
            if ($urandom_range(0, 9) != 0) push_byte(CH_QUOTE);
        end
        else if (pick < 45)
        begin
            // Number: optional minus, digits, optional fraction and exponent.
            // No digits after a minus gives the lone minus, no digits after a
            // dot the stray dot, and no exponent digits the exponent error.
            n = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) push_byte(CH_MINUS);
            else if (n == 0) n = 1;
            repeat (n) push_byte(random_digit());
            if ($urandom_range(0, 2) == 0)
            begin
                push_byte(CH_DOT);
                repeat ($urandom_range(0, 3)) push_byte(random_digit());
            end
            if ($urandom_range(0, 3) == 0)
            begin
                push_byte($urandom_range(0, 1) ? 8'("e") : 8'("E"));
                if ($urandom_range(0, 1)) push_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                repeat ($urandom_range(0, 2)) push_byte(random_digit());
            end
        end
        else if (pick < 55)
        begin
            // Keywords, now and then cut short or extended.
            case ($urandom_range(0, 2))
                0: word = "true";
                1: word = "false";
                default: word = "null";
            endcase
            n = $urandom_range(0, 9);
            if (n == 0) word = word.substr(0, word.len() - 2);
            push_text(word);
            if (n == 1) push_byte(random_letter());
        end
        else if (pick < 65)
        begin
            push_byte(random_letter());
            repeat ($urandom_range(0, 7))
            begin
                case ($urandom_range(0, 3))
                    0: push_byte(random_digit());
                    1: push_byte(CH_MINUS);
                    default: push_byte(random_letter());
                endcase
            end
        end
        else if (pick < 72)
        begin
            // Hash comment up to the end of the line.
            push_byte(CH_HASH);
            repeat ($urandom_range(0, 6))
            begin
                c = 8'($urandom_range(0, 255));
                push_byte(c == CH_LF ? 8'("x") : c);
            end
            push_byte(CH_LF);
        end
        else if (pick < 82)
        begin
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 3))
                    0: push_byte(CH_SPACE);
                    1: push_byte(CH_TAB);
                    2: push_byte(CH_CR);
                    default: push_byte(CH_LF);
                endcase
            end
        end
        else if (pick < 95)
        begin
            // Any byte at all, which covers NUL and the upper half.
            push_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            push_eos();
        end
        if ($urandom_range(0, 1)) push_byte($urandom_range(0, 2) ? CH_SPACE : CH_LF);
    endtask

    initial
    begin
        lexer_reset();

        // Directed text: lone minus, a dot with no digit after it, a missing
        // exponent digit, a comment, a string with an escaped line feed, NUL
        // and 0xFF, a keyword, a number ending in a dot at end of source, and
        // an unterminated string.
        push_text("[-,1.x 2e}#z\n\"\\\n\":");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("true 7.");
        push_eos();
        push_text("\"ab");
        push_eos();

        while (source_bytes.size() < SOURCE_ITEMS) add_random_lexeme();
        push_eos();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every item to be taken and every token to come back, then
        // keep the clock running so that any stray token can still show.
        while (source_bytes.size() != 0 || s_tvalid || token_queue.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d input transfers with %0d end-of-source marks; checked %0d tokens.",
                 items_sent, eos_sent, tokens_checked);
        $display("Token kinds covered: %0d of 15; error codes covered: %0d of 4.",
                 $countones(kinds_seen), $countones(errors_seen));
        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d tokens still expected.", token_queue.size());
        $display("FAILURE");
        $finish;
    end

endmodule
